// ===== hdl/hdc_pkg.sv =====
// Package for the haversine distance core: fixed-point constants and the
// arctangent table function shared by the CORDIC cells and the top level.
// No dependencies.
`default_nettype none

package hdc_pkg;

  // Stage count limits and default
  localparam int CORDIC_STAGES_DEF = 24;
  localparam int MAX_STAGES        = 40;

  // Widths
  localparam int QW  = 64;  // Q60 vector and angle width
  localparam int UW  = 34;  // raw angle difference, units of 2^-24 degree
  localparam int AW  = 36;  // angle reduction width
  localparam int RW  = 32;  // reduced angle width
  localparam int SW  = 34;  // Q30 sine and cosine width
  localparam int NW  = 61;  // square root radicand width
  localparam int RSW = 62;  // square root partial result width
  localparam int SQRT_STEPS = 31;
  localparam int DW  = 33;  // distance width

  // Q60 constants
  localparam logic signed [QW-1:0] PI_Q60   = 64'sh3243F6A8885A308D;
  localparam logic signed [QW-1:0] HALF_PI_Q60 = PI_Q60 / 2;
  localparam logic signed [QW-1:0] ONE_Q60  = 64'sd1 <<< 60;
  localparam logic signed [QW-1:0] KINV_Q60 = 64'sd700114967507363242;
  localparam logic signed [QW-1:0] DEG_TO_Q60_W = (PI_Q60 / 180 + (64'sd1 <<< 23)) >>> 24;
  localparam logic signed [RW-1:0] DEG_TO_Q60 = DEG_TO_Q60_W[RW-1:0];

  // Turn constants in units of 2^-24 degree
  localparam logic signed [AW-1:0] FULL_TURN    = 36'sd6039797760;
  localparam logic signed [AW-1:0] HALF_TURN    = 36'sd3019898880;
  localparam logic signed [AW-1:0] QUARTER_TURN = 36'sd1509949440;

  // Radius scaled by 512 and distance ceiling
  localparam logic [31:0]   RADIUS_512 = 32'd3261955677;
  localparam logic [DW-1:0] DIST_MAX   = 33'd5124000000;

  // Unsigned shift-and-subtract quotient, evaluated at elaboration only
  function automatic logic [QW-1:0] quot_elab(input logic [QW-1:0] num,
                                              input logic [QW-1:0] den);
    logic [QW-1:0] quo;
    logic [QW:0]   rem;
    quo = '0;
    rem = '0;
    for (int b = QW - 1; b >= 0; b--) begin
      rem = {rem[QW-1:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Arctangent of 2^-i in Q60: pi/4 for i = 0, else from the truncated power series
  function automatic logic signed [QW-1:0] atan_q60(input int i);
    logic signed [QW-1:0] sum;
    logic signed [QW-1:0] term;
    int k;
    sum = '0;
    if (i == 0) begin
      sum = (PI_Q60 + 64'sd2) >>> 2;
    end else begin
      for (k = 0; k < 31; k++) begin
        if (i * (2 * k + 1) <= 60) begin
          term = $signed(quot_elab(64'd1 << (60 - i * (2 * k + 1)),
                                   QW'(2 * k + 1)));
          if ((k & 1) == 1) sum = sum - term;
          else sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/haversine_distance_core.sv =====
// Top level of the haversine great-circle distance core.
// Depends on hdc_pkg, hdc_sincos, hdc_sqrt_cell and hdc_cordic_cell.
//
//   channel | direction | handshake            | payload
//   in      | sink      | in_valid / in_ready  | lat_first lon_first lat_second lon_second
//   out     | source    | out_valid / out_ready | arc_distance
//
// Fully pipelined: one item per cycle while the output is not stalled; the path
// runs through the two CORDIC cell chains and the 31-step square root chain.
// Reset clears only the valid pipeline; data registers are not reset.
// A stalled output freezes the whole pipeline and drops in_ready.
`default_nettype none

module haversine_distance_core #(
  parameter int CORDIC_STAGES = hdc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic signed [30:0]     lat_first,
  input  wire logic signed [31:0]     lon_first,
  input  wire logic signed [30:0]     lat_second,
  input  wire logic signed [31:0]     lon_second,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [hdc_pkg::DW-1:0]      arc_distance
);

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + 40;
  localparam int QW  = hdc_pkg::QW;
  localparam int SW  = hdc_pkg::SW;
  localparam int UW  = hdc_pkg::UW;

  logic            en;
  logic [LAT-1:0]  vld;
  logic [LAT-1:0]  idn;

  logic signed [UW-1:0] u_lat, u_lon, u_c1, u_c2;
  logic signed [SW-1:0] s_lat, s_lon, c1, c2, c_lat_unused, c_lon_unused, s1_unused, s2_unused;

  logic signed [QW-1:0] p_lat, p_cc, p_lon;
  logic signed [QW-1:0] p_lat_b, q_b;
  logic signed [QW-1:0] a_sum;
  logic [hdc_pkg::NW-1:0] ua, om;

  logic [hdc_pkg::NW-1:0]  sn_y [0:hdc_pkg::SQRT_STEPS];
  logic [hdc_pkg::RSW-1:0] sr_y [0:hdc_pkg::SQRT_STEPS];
  logic [hdc_pkg::NW-1:0]  sn_x [0:hdc_pkg::SQRT_STEPS];
  logic [hdc_pkg::RSW-1:0] sr_x [0:hdc_pkg::SQRT_STEPS];

  logic signed [QW-1:0] vx [0:N];
  logic signed [QW-1:0] vy [0:N];
  logic signed [QW-1:0] vz [0:N];

  logic signed [QW-1:0] zc;
  logic [QW-1:0]        cq;
  logic [QW-1:0]        hi_p, lo_p;
  logic [QW-1:0]        p_sum;
  logic [QW-1:0]        d_full;

  // Advance everything unless the output item is held
  assign en        = !(vld[LAT-1] && !out_ready);
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) idn <= {idn[LAT-2:0], (lat_first == lat_second) && (lon_first == lon_second)};
  end

  // Capture the four angles
  always_ff @(posedge clk) begin
    if (en) begin
      u_lat <= UW'(lat_second) - UW'(lat_first);
      u_lon <= UW'(lon_second) - UW'(lon_first);
      u_c1  <= UW'(lat_first) <<< 1;
      u_c2  <= UW'(lat_second) <<< 1;
    end
  end

  hdc_sincos #(.STAGES(N)) u_sc_lat (
    .clk(clk), .en(en), .angle(u_lat), .sin_q30(s_lat), .cos_q30(c_lat_unused));
  hdc_sincos #(.STAGES(N)) u_sc_lon (
    .clk(clk), .en(en), .angle(u_lon), .sin_q30(s_lon), .cos_q30(c_lon_unused));
  hdc_sincos #(.STAGES(N)) u_sc_c1 (
    .clk(clk), .en(en), .angle(u_c1), .sin_q30(s1_unused), .cos_q30(c1));
  hdc_sincos #(.STAGES(N)) u_sc_c2 (
    .clk(clk), .en(en), .angle(u_c2), .sin_q30(s2_unused), .cos_q30(c2));

  // Square and cross products
  always_ff @(posedge clk) begin
    if (en) begin
      p_lat <= QW'(s_lat) * QW'(s_lat);
      p_cc  <= QW'(c1) * QW'(c2);
      p_lon <= QW'(s_lon) * QW'(s_lon);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_lat_b <= p_lat;
      q_b     <= (p_cc >>> 30) * (p_lon >>> 30);
    end
  end

  // Form the haversine term and clamp it to [0, 1]
  always_comb a_sum = p_lat_b + q_b;

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_sum < 0) begin
        ua <= '0;
        om <= hdc_pkg::ONE_Q60[hdc_pkg::NW-1:0];
      end else if (a_sum > hdc_pkg::ONE_Q60) begin
        ua <= hdc_pkg::ONE_Q60[hdc_pkg::NW-1:0];
        om <= '0;
      end else begin
        ua <= a_sum[hdc_pkg::NW-1:0];
        om <= hdc_pkg::ONE_Q60[hdc_pkg::NW-1:0] - a_sum[hdc_pkg::NW-1:0];
      end
    end
  end

  assign sn_y[0] = ua;
  assign sr_y[0] = '0;
  assign sn_x[0] = om;
  assign sr_x[0] = '0;

  // Two square root chains, one digit per cell
  for (genvar k = 0; k < hdc_pkg::SQRT_STEPS; k++) begin : g_sqrt
    hdc_sqrt_cell #(.BIT_EXP(60 - 2 * k)) u_sq_y (
      .clk(clk), .en(en), .n_in(sn_y[k]), .res_in(sr_y[k]),
      .n_out(sn_y[k+1]), .res_out(sr_y[k+1]));
    hdc_sqrt_cell #(.BIT_EXP(60 - 2 * k)) u_sq_x (
      .clk(clk), .en(en), .n_in(sn_x[k]), .res_in(sr_x[k]),
      .n_out(sn_x[k+1]), .res_out(sr_x[k+1]));
  end

  assign vy[0] = QW'(sr_y[hdc_pkg::SQRT_STEPS]) <<< 28;
  assign vx[0] = QW'(sr_x[hdc_pkg::SQRT_STEPS]) <<< 28;
  assign vz[0] = '0;

  // Vectoring chain for atan2
  for (genvar i = 0; i < N; i++) begin : g_vec
    hdc_cordic_cell #(.STAGE(i), .VECTOR(1'b1)) u_vec (
      .clk(clk), .en(en), .x_in(vx[i]), .y_in(vy[i]), .z_in(vz[i]),
      .x_out(vx[i+1]), .y_out(vy[i+1]), .z_out(vz[i+1]));
  end

  // Clamp the arc angle and scale by the radius
  always_comb begin
    if (vz[N] < 0) zc = '0;
    else if (vz[N] > hdc_pkg::HALF_PI_Q60) zc = hdc_pkg::HALF_PI_Q60;
    else zc = vz[N];
    cq = QW'(zc) << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_p <= QW'(cq[62:32]) * QW'(hdc_pkg::RADIUS_512);
      lo_p <= (QW'(cq[31:0]) * QW'(hdc_pkg::RADIUS_512)) >> 32;
    end
  end

  // Round, saturate and force zero for identical points
  always_comb begin
    p_sum  = hi_p + lo_p;
    d_full = (p_sum + (QW'(1) << 28)) >> 29;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (idn[LAT-2]) arc_distance <= '0;
      else if (d_full > QW'(hdc_pkg::DIST_MAX)) arc_distance <= hdc_pkg::DIST_MAX;
      else arc_distance <= d_full[hdc_pkg::DW-1:0];
    end
  end

  // Checks
  a_dist_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> arc_distance <= hdc_pkg::DIST_MAX)
    else $error("distance above ceiling");

  a_ident_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && idn[LAT-1]) |-> arc_distance == '0)
    else $error("identical points gave nonzero distance");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output held");

  // The clamp stage holds a valid item when vld[N+6] is set
  a_term_clamp: assert property (@(posedge clk) disable iff (rst)
    vld[N+6] |-> (ua + om) == hdc_pkg::ONE_Q60[hdc_pkg::NW-1:0])
    else $error("haversine term out of range");

endmodule

`default_nettype wire

// ===== hdl/hdc_cordic_cell.sv =====
// One CORDIC micro-rotation cell, rotation or vectoring mode, registered.
// Depends on hdc_pkg for widths and the arctangent table.
`default_nettype none

module hdc_cordic_cell #(
  parameter int STAGE  = 0,
  parameter bit VECTOR = 1'b0
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [hdc_pkg::QW-1:0] x_in,
  input  wire logic signed [hdc_pkg::QW-1:0] y_in,
  input  wire logic signed [hdc_pkg::QW-1:0] z_in,
  output logic signed [hdc_pkg::QW-1:0]      x_out,
  output logic signed [hdc_pkg::QW-1:0]      y_out,
  output logic signed [hdc_pkg::QW-1:0]      z_out
);

  localparam logic signed [hdc_pkg::QW-1:0] ATAN = hdc_pkg::atan_q60(STAGE);

  logic signed [hdc_pkg::QW-1:0] xs, ys;
  logic                          plus;

  // Pick the rotation direction from the angle or from the vector sign
  always_comb begin
    xs   = x_in >>> STAGE;
    ys   = y_in >>> STAGE;
    plus = VECTOR ? !(y_in > 0) : (z_in >= 0);
  end

  // Advance one micro-rotation
  always_ff @(posedge clk) begin
    if (en) begin
      if (plus) begin
        x_out <= x_in - ys;
        y_out <= y_in + xs;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + ys;
        y_out <= y_in - xs;
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hdc_sqrt_cell.sv =====
// One digit step of a floor integer square root, registered.
// Depends on hdc_pkg for widths.
`default_nettype none

module hdc_sqrt_cell #(
  parameter int BIT_EXP = 60
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [hdc_pkg::NW-1:0]   n_in,
  input  wire logic [hdc_pkg::RSW-1:0]  res_in,
  output logic [hdc_pkg::NW-1:0]        n_out,
  output logic [hdc_pkg::RSW-1:0]       res_out
);

  localparam logic [hdc_pkg::RSW-1:0] BIT = hdc_pkg::RSW'(1) << BIT_EXP;

  logic [hdc_pkg::RSW-1:0] trial;

  always_comb trial = res_in + BIT;

  // Subtract the trial value when it fits, then shift the root
  always_ff @(posedge clk) begin
    if (en) begin
      if (hdc_pkg::RSW'(n_in) >= trial) begin
        n_out   <= n_in - trial[hdc_pkg::NW-1:0];
        res_out <= (res_in >> 1) + BIT;
      end else begin
        n_out   <= n_in;
        res_out <= res_in >> 1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hdc_sincos.sv =====
// Sine and cosine of an angle in units of 2^-24 degree, Q30 results.
// Reduce, scale to Q60 radians, run a chain of rotation cells.
// Depends on hdc_pkg and hdc_cordic_cell.
`default_nettype none

module hdc_sincos #(
  parameter int STAGES = hdc_pkg::CORDIC_STAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [hdc_pkg::UW-1:0] angle,
  output logic signed [hdc_pkg::SW-1:0]      sin_q30,
  output logic signed [hdc_pkg::SW-1:0]      cos_q30
);

  logic signed [hdc_pkg::AW-1:0] u, r0, r1;
  logic                          neg_next;
  logic signed [hdc_pkg::RW-1:0] red;
  logic                          red_neg;
  logic signed [hdc_pkg::QW-1:0] red_ext;
  logic signed [hdc_pkg::QW-1:0] z0;
  logic signed [hdc_pkg::QW-1:0] cx [0:STAGES];
  logic signed [hdc_pkg::QW-1:0] cy [0:STAGES];
  logic signed [hdc_pkg::QW-1:0] cz [0:STAGES];
  logic [STAGES:0]               neg_pipe;
  logic signed [hdc_pkg::QW-1:0] x_fin;

  // Wrap into half turns, then fold into the right half plane
  always_comb begin
    u = hdc_pkg::AW'(angle);
    if (u < -hdc_pkg::HALF_TURN) r0 = u + hdc_pkg::FULL_TURN;
    else if (u >= hdc_pkg::HALF_TURN) r0 = u - hdc_pkg::FULL_TURN;
    else r0 = u;
    neg_next = 1'b0;
    r1 = r0;
    if (r0 > hdc_pkg::QUARTER_TURN) begin
      r1 = hdc_pkg::HALF_TURN - r0;
      neg_next = 1'b1;
    end else if (r0 < -hdc_pkg::QUARTER_TURN) begin
      r1 = -hdc_pkg::HALF_TURN - r0;
      neg_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red     <= r1[hdc_pkg::RW-1:0];
      red_neg <= neg_next;
    end
  end

  // Scale to Q60 radians
  always_comb red_ext = hdc_pkg::QW'(red);

  always_ff @(posedge clk) begin
    if (en) begin
      z0          <= red_ext * hdc_pkg::QW'(hdc_pkg::DEG_TO_Q60);
      neg_pipe[0] <= red_neg;
    end
  end

  assign cx[0] = hdc_pkg::KINV_Q60;
  assign cy[0] = '0;
  assign cz[0] = z0;

  // Chain of rotation cells
  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    hdc_cordic_cell #(.STAGE(i), .VECTOR(1'b0)) u_cell (
      .clk   (clk),
      .en    (en),
      .x_in  (cx[i]),
      .y_in  (cy[i]),
      .z_in  (cz[i]),
      .x_out (cx[i+1]),
      .y_out (cy[i+1]),
      .z_out (cz[i+1])
    );

    always_ff @(posedge clk) begin
      if (en) neg_pipe[i+1] <= neg_pipe[i];
    end
  end

  // Apply the cosine sign and cut to Q30
  always_comb x_fin = neg_pipe[STAGES] ? -cx[STAGES] : cx[STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q30 <= hdc_pkg::SW'(cy[STAGES] >>> 30);
      cos_q30 <= hdc_pkg::SW'(x_fin >>> 30);
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/haversine_distance_checker.sv =====
// Checker for the haversine distance core: watches both channels, predicts
// each distance with an independent fixed-point model and compares in order.
// Depends on hdc_pkg for widths only.
module haversine_distance_checker #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic signed [30:0]     lat_first,
  input  logic signed [31:0]     lon_first,
  input  logic signed [30:0]     lat_second,
  input  logic signed [31:0]     lon_second,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [hdc_pkg::DW-1:0] arc_distance,
  output int                     fail_count,
  output int                     pending_count,
  output int                     seen_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_Q = 64'sh3243F6A8885A308D;
  localparam longint ONE_Q = 64'sd1 <<< 60;
  localparam longint GAIN_Q = 64'sd700114967507363242;
  localparam longint DEG_SCALE = (PI_Q / 180 + (64'sd1 <<< 23)) >>> 24;
  localparam longint TURN = 64'sd360 <<< 24;
  localparam longint HALF = 64'sd180 <<< 24;
  localparam longint QUART = 64'sd90 <<< 24;
  localparam logic [63:0] RADIUS_X512 = 64'd3261955677;
  localparam logic [63:0] DIST_CEIL = 64'd5124000000;

  longint arctan_tab [0:39];
  logic [hdc_pkg::DW-1:0] distance_fifo [$];

  // Build arctangent table: pi/4 at index 0, else the truncated power series
  initial begin
    longint acc;
    longint term;
    int k;
    arctan_tab[0] = (PI_Q + 2) >>> 2;
    for (int i = 1; i < 40; i++) begin
      acc = 0;
      k = 0;
      while (i * (2 * k + 1) <= 60) begin
        term = (64'sd1 <<< (60 - i * (2 * k + 1))) / (2 * k + 1);
        acc = (k % 2 == 1) ? acc - term : acc + term;
        k++;
      end
      arctan_tab[i] = acc;
    end
  end

  function automatic int stages();
    return (CORDIC_STAGES < 1) ? 1 : (CORDIC_STAGES > 40 ? 40 : CORDIC_STAGES);
  endfunction

  // Rotation CORDIC; angle in 2^-24 degree, outputs Q30
  function automatic void rotate_angle(input longint ang, output longint sn,
                                       output longint cs);
    longint r, x, y, z, xs, ys;
    bit flip;
    r = ang % TURN;
    flip = 0;
    x = GAIN_Q;
    y = 0;
    if (r < 0) r += TURN;
    if (r >= HALF) r -= TURN;
    if (r > QUART) begin
      r = HALF - r;
      flip = 1;
    end else if (r < -QUART) begin
      r = -HALF - r;
      flip = 1;
    end
    z = r * DEG_SCALE;
    for (int i = 0; i < stages(); i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_tab[i];
      end else begin
        x += ys; y -= xs; z += arctan_tab[i];
      end
    end
    if (flip) x = -x;
    sn = y >>> 30;
    cs = x >>> 30;
  endfunction

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [hdc_pkg::DW-1:0] great_circle(
    input logic signed [30:0] la, input logic signed [31:0] oa,
    input logic signed [30:0] lb, input logic signed [31:0] ob);
    longint s_lat, s_lon, c1, c2, unused, a, x, y, z, xs, ys, cq;
    logic [63:0] p, d;
    if (la == lb && oa == ob) return '0;
    rotate_angle(longint'(lb) - longint'(la), s_lat, unused);
    rotate_angle(longint'(ob) - longint'(oa), s_lon, unused);
    rotate_angle(longint'(la) * 2, unused, c1);
    rotate_angle(longint'(lb) * 2, unused, c2);
    a = s_lat * s_lat + ((c1 * c2) >>> 30) * ((s_lon * s_lon) >>> 30);
    if (a < 0) a = 0;
    if (a > ONE_Q) a = ONE_Q;
    y = longint'(floor_root(a)) <<< 28;
    x = longint'(floor_root(ONE_Q - a)) <<< 28;
    z = 0;
    // Vectoring CORDIC for atan2
    for (int i = 0; i < stages(); i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += arctan_tab[i];
      end else begin
        x -= ys; y += xs; z -= arctan_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > PI_Q / 2) z = PI_Q / 2;
    cq = 2 * z;
    p = (64'(cq) >> 32) * RADIUS_X512 + (((64'(cq) & 64'hFFFFFFFF) * RADIUS_X512) >> 32);
    d = (p + (64'd1 << 28)) >> 29;
    if (d > DIST_CEIL) d = DIST_CEIL;
    return d[hdc_pkg::DW-1:0];
  endfunction

  assign pending_count = distance_fifo.size();

  // Predict on input items, compare on output items
  always @(posedge clk) begin
    logic [hdc_pkg::DW-1:0] want;
    if (rst) begin
      fail_count <= 0;
      seen_count <= 0;
    end else begin
      if (in_valid && in_ready)
        distance_fifo = {distance_fifo,
                         great_circle(lat_first, lon_first, lat_second, lon_second)};
      if (out_valid && out_ready) begin
        seen_count <= seen_count + 1;
        if (distance_fifo.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0d", $time, arc_distance);
          fail_count <= fail_count + 1;
        end else begin
          want = distance_fifo.pop_front();
          if (want !== arc_distance) begin
            $display("%0t: arc_distance mismatch, expected %0d, actual %0d",
                     $time, want, arc_distance);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_haversine_distance_core.sv =====
// Top of the haversine distance core testbench: clock, reset, stimulus,
// output stalls and verdict. Depends on haversine_distance_checker and the core.
module tb_haversine_distance_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [30:0] LAT_MAX = 31'sd754974720;
  localparam logic signed [31:0] LON_MAX = 32'sd1509949440;
  localparam int LATENCY = 2 * 24 + 40;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic out_ready = 0;
  logic signed [30:0] lat_first = '0;
  logic signed [31:0] lon_first = '0;
  logic signed [30:0] lat_second = '0;
  logic signed [31:0] lon_second = '0;
  logic in_ready, out_valid;
  logic [hdc_pkg::DW-1:0] arc_distance;
  int fail_count, pending_count, seen_count;
  int cycle_count = 0;
  bit long_hold = 0;

  haversine_distance_core DUT (.*);
  haversine_distance_checker CHK (.*);

  initial begin
    forever #6 clk = ~clk;
  end

  // Abort on runaway
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stall the receiver on its own pattern, with one or more long hold-offs
  initial begin
    int mode;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (300) @(posedge clk);
        long_hold = 0;
      end
      mode = (cycle_count / 500) % 3;
      if (mode == 0) out_ready <= 1;
      else if (mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
      else out_ready <= ($urandom_range(0, 1) == 0);
    end
  end

  function automatic logic signed [30:0] pick_lat();
    case ($urandom_range(0, 5))
      0: return LAT_MAX;
      1: return -LAT_MAX;
      2: return 31'($urandom);  // any bit pattern wraps
      default: return 31'($signed($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_lon();
    case ($urandom_range(0, 5))
      0: return LON_MAX;
      1: return -LON_MAX;
      2: return $urandom;
      default: return $signed(32'($urandom_range(0, 32'd3019898880))) - LON_MAX;
    endcase
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_points(input logic signed [30:0] la, input logic signed [31:0] oa,
                             input logic signed [30:0] lb, input logic signed [31:0] ob);
    lat_first <= la;
    lon_first <= oa;
    lat_second <= lb;
    lon_second <= ob;
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic signed [30:0] la, lb;
    logic signed [31:0] oa, ob;
    int burst;
    int gap;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: identical points, poles, antipodes, extremes, tiny steps
    send_points(0, 0, 0, 0);
    send_points(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX);
    send_points(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX);
    send_points(LAT_MAX, 0, -LAT_MAX, 0);
    send_points(0, -LON_MAX, 0, LON_MAX);
    send_points(0, 0, 0, LON_MAX);
    send_points(0, 0, 0, 1);
    send_points(0, 0, 1, 0);
    send_points(LAT_MAX, 0, LAT_MAX, LON_MAX);
    send_points(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_points(31'h3FFFFFFF, 32'h7FFFFFFF, 31'h40000000, 32'h80000000);
    send_points(31'h40000000, 32'h80000000, 31'h3FFFFFFF, 32'h7FFFFFFF);
    send_points(-1, -1, 0, 0);
    send_points(31'h2AAAAAAA, 32'h55555555, 31'h55555555, 32'hAAAAAAAA);
    send_points(0, 0, 0, 32'sd754974720 * 2 - 1);
    send_points(12345678, 87654321, 12345678, 87654321);
    // Random bursts: half small separations around a random point, the rest identical or random pairs
    for (int n = 0; n < 1100; n += burst) begin
      burst = $urandom_range(1, 40);
      if (n > 500 && n < 550) long_hold = 1;
      for (int j = 0; j < burst; j++) begin
        la = pick_lat();
        oa = pick_lon();
        case ($urandom_range(0, 3))
          0: begin lb = pick_lat(); ob = pick_lon(); end
          1: begin lb = la; ob = oa; end
          default: begin
            lb = la + $signed(31'($urandom_range(0, 2000000))) - 31'sd1000000;
            ob = oa + $signed(32'($urandom_range(0, 2000000))) - 32'sd1000000;
          end
        endcase
        send_points(la, oa, lb, ob);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 0;
    while (pending_count != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    $display("Sent %0d distance items incl. identical, polar, antipodal, wrapped", seen_count);
    $display("and near-neighbor pairs under bursty input and output stalls.");
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/hdc_pkg.sv
hdl/hdc_cordic_cell.sv
hdl/hdc_sqrt_cell.sv
hdl/hdc_sincos.sv
hdl/haversine_distance_core.sv
tb/sv/haversine_distance_checker.sv
tb/sv/tb_haversine_distance_core.sv
